// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that ante implies cons in the same cycle, outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/hsvca_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvca_pkg
// Register indexes and mode codes of the HSV color adjuster.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsvca_pkg;

  typedef enum logic [2:0] {
    REG_HUE_OFFSET    = 3'd0,
    REG_SAT_GAIN      = 3'd1,
    REG_VAL_GAIN      = 3'd2,
    REG_MODIFY_MODE   = 3'd3,
    REG_USE_INTENSITY = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_BOTH   = 2'd0,
    MODE_STROKE = 2'd1,
    MODE_FILL   = 2'd2,
    MODE_ALL    = 2'd3
  } mode_t;

  localparam logic OP_FILL   = 1'b0;
  localparam logic OP_STROKE = 1'b1;

endpackage

// ===== sv/hsv_color_adjust.sv =====
// FRAC_BITS + 6 register stages lie between an input beat and its result beat (18 at 12).
// Throughput: one beat per unstalled cycle; the two hue/saturation dividers are unrolled
// one quotient bit per stage, so every stage takes a new beat each unstalled cycle.
// A stalled output freezes the whole pipeline in place; nothing is dropped.
// Reset (synchronous, rst_n low): all valid bits clear, registers take
// hue_offset 0.5, gains 1.0, mode both, intensity off.
// ----------------------------------------------------------------------------
// hsv_color_adjust
// Hue / saturation / value adjustment of one color beat, deep pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module hsv_color_adjust
  import hsvca_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_wr_en,
  input  logic [2:0]           cfg_index,
  input  logic [FRAC_BITS+1:0] cfg_data,
  // input beat
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_operation,
  input  logic [FRAC_BITS:0]   in_red_in,
  input  logic [FRAC_BITS:0]   in_green_in,
  input  logic [FRAC_BITS:0]   in_blue_in,
  input  logic [FRAC_BITS:0]   in_alpha_in,
  input  logic                 in_mat_valid,
  input  logic [FRAC_BITS:0]   in_mat_red,
  input  logic [FRAC_BITS:0]   in_mat_green,
  input  logic [FRAC_BITS:0]   in_mat_blue,
  input  logic [FRAC_BITS:0]   in_mat_alpha,
  input  logic [FRAC_BITS:0]   in_intensity,
  // result beat
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_BITS+1:0] out_red_out,
  output logic [FRAC_BITS+1:0] out_green_out,
  output logic [FRAC_BITS+1:0] out_blue_out,
  output logic [FRAC_BITS:0]   out_alpha_out,
  output logic                 out_adjusted
);

  localparam int F   = FRAC_BITS;
  localparam int W   = F + 1;       // color / quotient width
  localparam int G   = F + 2;       // output / gain width
  localparam int DW  = 2 * F + 2;   // divider remainder width
  localparam int TW  = 2 * F + 1;   // channel term width
  localparam int HW  = F + 4;       // hue sum width
  localparam int NW  = F + 5;       // signed ramp width
  localparam int PW  = TW + W + 1;  // channel product width

  localparam logic [W-1:0]   ONE     = W'(1) << F;
  localparam logic [G-1:0]   TWO     = G'(1) << (F + 1);
  localparam logic [2*W:0]   HALF    = (2*W+1)'(1) << (F - 1);
  localparam logic [HW-1:0]  SIX     = HW'(6) << F;
  localparam logic [HW-1:0]  TWELVE  = HW'(12) << F;
  localparam logic [HW-1:0]  THREE   = HW'(3) << F;
  localparam logic [TW-1:0]  FULL    = TW'(1) << (2 * F);
  localparam logic [PW-1:0]  FHALF   = PW'(1) << (2 * F - 1);

  // Beat context carried alongside the arithmetic through every stage.
  typedef struct packed {
    logic         skip;
    logic [W-1:0] pr;
    logic [W-1:0] pg;
    logic [W-1:0] pb;
    logic [W-1:0] alpha;
    logic         gray;
    logic [2:0]   base;
    logic         neg;
    logic [W-1:0] mx;
    logic [W-1:0] k;
    logic [W-1:0] fh;
    logic [G-1:0] fs;
    logic [G-1:0] fv;
  } ctx_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [W-1:0] hue_offset_r;
  logic [G-1:0] sat_gain_r;
  logic [G-1:0] val_gain_r;
  logic [1:0]   modify_mode_r;
  logic         use_intensity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_offset_r    <= W'(1) << (F - 1);
      sat_gain_r      <= G'(ONE);
      val_gain_r      <= G'(ONE);
      modify_mode_r   <= MODE_BOTH;
      use_intensity_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_HUE_OFFSET:    hue_offset_r    <= cfg_data[W-1:0];
        REG_SAT_GAIN:      sat_gain_r      <= cfg_data[G-1:0];
        REG_VAL_GAIN:      val_gain_r      <= cfg_data[G-1:0];
        REG_MODIFY_MODE:   modify_mode_r   <= cfg_data[1:0];
        REG_USE_INTENSITY: use_intensity_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances together whenever the output register can move.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  function automatic logic [W-1:0] sat1(input logic [W-1:0] x);
    sat1 = (x > ONE) ? ONE : x;
  endfunction

  // --------------------------------------------------------------------------
  // Stage A: fallback select, min / max / chroma, hue sector
  // --------------------------------------------------------------------------
  logic         a_valid_r;
  ctx_t         a_ctx_r, a_ctx_nxt;
  logic [W-1:0] a_anum_r, a_anum_nxt;
  logic [W-1:0] a_c_r, a_c_nxt;

  always_comb begin
    logic         fb, stroke;
    logic [W-1:0] r, g, b, mn;
    logic [W:0]   num;
    stroke = (in_operation == OP_STROKE);
    fb = (in_alpha_in == '0) && in_mat_valid && (in_mat_alpha != '0);
    r  = fb ? sat1(in_mat_red)   : sat1(in_red_in);
    g  = fb ? sat1(in_mat_green) : sat1(in_green_in);
    b  = fb ? sat1(in_mat_blue)  : sat1(in_blue_in);
    a_ctx_nxt      = '0;
    a_ctx_nxt.skip = ((modify_mode_r == MODE_STROKE) && !stroke) ||
                     ((modify_mode_r == MODE_FILL) && stroke);
    a_ctx_nxt.pr   = in_red_in;
    a_ctx_nxt.pg   = in_green_in;
    a_ctx_nxt.pb   = in_blue_in;
    a_ctx_nxt.alpha = (fb && !a_ctx_nxt.skip) ? ONE : in_alpha_in;
    a_ctx_nxt.k    = (stroke && use_intensity_r) ? sat1(in_intensity) : ONE;
    a_ctx_nxt.mx = r;
    if (g > a_ctx_nxt.mx) a_ctx_nxt.mx = g;
    if (b > a_ctx_nxt.mx) a_ctx_nxt.mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    a_c_nxt = a_ctx_nxt.mx - mn;
    a_ctx_nxt.gray = (a_c_nxt == '0);
    if (a_ctx_nxt.mx == r) begin
      num = {1'b0, g} - {1'b0, b};
      a_ctx_nxt.base = 3'd0;
    end else if (a_ctx_nxt.mx == g) begin
      num = {1'b0, b} - {1'b0, r};
      a_ctx_nxt.base = 3'd2;
    end else begin
      num = {1'b0, r} - {1'b0, g};
      a_ctx_nxt.base = 3'd4;
    end
    a_ctx_nxt.neg = num[W];
    a_anum_nxt = num[W] ? W'(-num) : num[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ctx_r  <= a_ctx_nxt;
      a_anum_r <= a_anum_nxt;
      a_c_r    <= a_c_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: scaled factors, divider operands
  // --------------------------------------------------------------------------
  logic          d_valid_r [0:W];
  ctx_t          d_ctx_r   [0:W];
  logic [DW-1:0] d_remh_r  [0:W];
  logic [DW-1:0] d_rems_r  [0:W];
  logic [W-1:0]  d_divh_r  [0:W];
  logic [W-1:0]  d_qh_r    [0:W];
  logic [W-1:0]  d_qs_r    [0:W];

  ctx_t          b_ctx_nxt;
  logic [2*W:0]  b_ph, b_ps, b_pv;

  always_comb begin
    b_ctx_nxt = a_ctx_r;
    b_ph = ((2*W+1)'(sat1(hue_offset_r)) * (2*W+1)'(a_ctx_r.k)) + HALF;
    b_ps = ((2*W+1)'((sat_gain_r > TWO) ? TWO : sat_gain_r) * (2*W+1)'(a_ctx_r.k)) + HALF;
    b_pv = ((2*W+1)'((val_gain_r > TWO) ? TWO : val_gain_r) * (2*W+1)'(a_ctx_r.k)) + HALF;
    b_ctx_nxt.fh = b_ph[F +: W];
    b_ctx_nxt.fs = b_ps[F +: G];
    b_ctx_nxt.fv = b_pv[F +: G];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r[0] <= 1'b0;
    end else if (en) begin
      d_valid_r[0] <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_ctx_r[0]  <= b_ctx_nxt;
      d_remh_r[0] <= (DW'(a_anum_r) << F) + DW'(a_c_r >> 1);
      d_rems_r[0] <= (DW'(a_c_r) << F) + DW'(a_ctx_r.mx >> 1);
      d_divh_r[0] <= a_c_r;
      d_qh_r[0]   <= '0;
      d_qs_r[0]   <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Divider stages: one quotient bit of each division per stage, MSB first
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < W; j++) begin : g_div
    localparam int BI = W - 1 - j;
    logic [DW:0] trh, trs;
    logic        geh, ges;
    logic [DW-1:0] remh_nxt, rems_nxt;
    logic [W-1:0]  qh_nxt, qs_nxt;

    always_comb begin
      trh = (DW+1)'(d_divh_r[j]) << BI;
      trs = (DW+1)'(d_ctx_r[j].mx) << BI;
      geh = ({1'b0, d_remh_r[j]} >= trh);
      ges = ({1'b0, d_rems_r[j]} >= trs);
      remh_nxt = geh ? DW'({1'b0, d_remh_r[j]} - trh) : d_remh_r[j];
      rems_nxt = ges ? DW'({1'b0, d_rems_r[j]} - trs) : d_rems_r[j];
      qh_nxt = d_qh_r[j];
      qs_nxt = d_qs_r[j];
      qh_nxt[BI] = geh;
      qs_nxt[BI] = ges;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_valid_r[j+1] <= 1'b0;
      end else if (en) begin
        d_valid_r[j+1] <= d_valid_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_ctx_r[j+1]  <= d_ctx_r[j];
        d_remh_r[j+1] <= remh_nxt;
        d_rems_r[j+1] <= rems_nxt;
        d_divh_r[j+1] <= d_divh_r[j];
        d_qh_r[j+1]   <= qh_nxt;
        d_qs_r[j+1]   <= qs_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: hue rotate and wrap, saturation and value gains
  // --------------------------------------------------------------------------
  logic          c_valid_r;
  ctx_t          c_ctx_r;
  logic [HW-1:0] c_h_r, c_h_nxt;
  logic [W-1:0]  c_s_r, c_s_nxt;
  logic [G-1:0]  c_v_r, c_v_nxt;

  always_comb begin
    logic signed [HW:0] hs;
    logic [HW-1:0]      t;
    logic [2*W+1:0]     ps, pv;
    logic [W-1:0]       s0;
    ctx_t               cx;
    cx = d_ctx_r[W];
    hs = $signed((HW+1)'(cx.base) << F);
    if (cx.neg) hs = hs - $signed((HW+1)'(d_qh_r[W]));
    else        hs = hs + $signed((HW+1)'(d_qh_r[W]));
    if (hs < 0) hs = hs + $signed({1'b0, SIX});
    if (cx.gray) hs = '0;
    s0 = cx.gray ? '0 : d_qs_r[W];
    t = HW'(hs) + HW'(6 * cx.fh) + THREE;
    if (t >= TWELVE)   c_h_nxt = t - TWELVE;
    else if (t >= SIX) c_h_nxt = t - SIX;
    else               c_h_nxt = t;
    ps = ((2*W+2)'(s0) * (2*W+2)'(cx.fs)) + (2*W+2)'(HALF);
    pv = ((2*W+2)'(cx.mx) * (2*W+2)'(cx.fv)) + (2*W+2)'(HALF);
    c_s_nxt = (ps[F +: G] > G'(ONE)) ? ONE : ps[F +: W];
    c_v_nxt = pv[F +: G];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= d_valid_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_ctx_r <= d_ctx_r[W];
      c_h_r   <= c_h_nxt;
      c_s_r   <= c_s_nxt;
      c_v_r   <= c_v_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: hexcone ramps and per-channel terms
  // --------------------------------------------------------------------------
  logic          e_valid_r;
  ctx_t          e_ctx_r;
  logic [G-1:0]  e_v_r;
  logic [TW-1:0] e_t_r   [0:2];
  logic [TW-1:0] e_t_nxt [0:2];

  function automatic logic [W-1:0] clamp01(input logic signed [NW-1:0] x);
    if (x < 0)                          clamp01 = '0;
    else if (x > $signed(NW'(ONE)))     clamp01 = ONE;
    else                                clamp01 = x[W-1:0];
  endfunction

  function automatic logic signed [NW-1:0] absn(input logic signed [NW-1:0] x);
    absn = (x < 0) ? -x : x;
  endfunction

  always_comb begin
    logic signed [NW-1:0] h, one_s, two_s, three_s, four_s;
    logic [W-1:0]         n [0:2];
    h       = $signed(NW'(c_h_r));
    one_s   = $signed(NW'(ONE));
    two_s   = one_s <<< 1;
    three_s = one_s + two_s;
    four_s  = two_s <<< 1;
    n[0] = clamp01(absn(h - three_s) - one_s);
    n[1] = clamp01(two_s - absn(h - two_s));
    n[2] = clamp01(two_s - absn(h - four_s));
    for (int i = 0; i < 3; i++) begin
      e_t_nxt[i] = FULL - (TW'(c_s_r) * TW'(ONE - n[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (en) begin
      e_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_ctx_r <= c_ctx_r;
      e_v_r   <= c_v_r;
      for (int i = 0; i < 3; i++) begin
        e_t_r[i] <= e_t_nxt[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: scale by value, round, pick pass-through for skipped beats
  // --------------------------------------------------------------------------
  logic          out_valid_r;
  logic [G-1:0]  out_red_r, out_green_r, out_blue_r;
  logic [W-1:0]  out_alpha_r;
  logic          out_adj_r;
  logic [PW-1:0] o_p [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_p[i] = (PW'(e_v_r) * PW'(e_t_r[i])) + FHALF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= e_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_alpha_r <= e_ctx_r.alpha;
      out_adj_r   <= !e_ctx_r.skip;
      if (e_ctx_r.skip) begin
        out_red_r   <= G'(e_ctx_r.pr);
        out_green_r <= G'(e_ctx_r.pg);
        out_blue_r  <= G'(e_ctx_r.pb);
      end else begin
        out_red_r   <= o_p[0][2*F +: G];
        out_green_r <= o_p[1][2*F +: G];
        out_blue_r  <= o_p[2][2*F +: G];
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_red_r;
  assign out_green_out = out_green_r;
  assign out_blue_out  = out_blue_r;
  assign out_alpha_out = out_alpha_r;
  assign out_adjusted  = out_adj_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_IMPL(a_sat_clamped, c_valid_r && !c_ctx_r.skip, c_s_r <= ONE,
               "saturation above one after clamp")
  `ASSERT_IMPL(a_val_range, out_valid && out_adjusted, out_red_out <= TWO,
               "adjusted red beyond two")
  `ASSERT_IMPL(a_skip_pass, out_valid && !out_adjusted, out_blue_out[G-1] == 1'b0,
               "pass-through blue wider than its input")

endmodule

// ===== verif/hsv_color_adjust_tb.sv =====
// ----------------------------------------------------------------------------
// hsv_color_adjust_tb
// Drives color beats through the HSV adjuster under random stalls and checks
// every result beat against a bit-exact fixed-point predictor of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_color_adjust_tb
  import hsvca_pkg::*;
();

  localparam int FB = 12;
  localparam longint ONE = 64'sd1 << FB;
  localparam int LATENCY = FB + 7;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic        op;
    logic [12:0] r, g, b, a;
    logic        mv;
    logic [12:0] mr, mg, mb, ma;
    logic [12:0] inten;
  } color_beat_t;

  typedef struct {
    logic [13:0] r, g, b;
    logic [12:0] a;
    logic        adj;
  } adj_color_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [13:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = 1'b0;
  logic [12:0] in_red_in = '0, in_green_in = '0, in_blue_in = '0, in_alpha_in = '0;
  logic in_mat_valid = 1'b0;
  logic [12:0] in_mat_red = '0, in_mat_green = '0, in_mat_blue = '0, in_mat_alpha = '0;
  logic [12:0] in_intensity = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [13:0] out_red_out, out_green_out, out_blue_out;
  logic [12:0] out_alpha_out;
  logic out_adjusted;

  always #2 clk = ~clk;

  hsv_color_adjust #(.FRAC_BITS(FB)) u_top (.*);

  // Shadow copy of the adjuster registers.
  longint hue_reg = 2048, sat_reg = 4096, val_reg = 4096;
  logic [1:0] mode_reg = MODE_BOTH;
  logic intens_reg = 1'b0;

  adj_color_t pending_colors[$];
  int send_idle_pct = 0, recv_idle_pct = 0;
  int recv_hold = 0;
  int mismatches = 0, results_seen = 0, beats_sent = 0, quiet_cycles = 0;

  function automatic longint sat_hi(longint x, longint hi);
    return (x > hi) ? hi : x;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + (ONE >>> 1)) >>> FB;
  endfunction

  function automatic longint clip01(longint x);
    return (x < 0) ? 0 : ((x > ONE) ? ONE : x);
  endfunction

  function automatic longint absl(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic logic [13:0] ramp_channel(longint v, longint s, longint n);
    longint t;
    t = v * (ONE * ONE - s * (ONE - n)) + ((ONE * ONE) >>> 1);
    return 14'(t >>> (2 * FB));
  endfunction

  function automatic adj_color_t predict_color(color_beat_t x);
    adj_color_t y;
    longint r, g, b, mx, mn, c, h6, s, v, k, fh, fs, fv, num, base, q;
    logic skip;
    skip = (mode_reg == MODE_STROKE && x.op == OP_FILL) ||
           (mode_reg == MODE_FILL && x.op == OP_STROKE);
    y.a = x.a;
    if (skip) begin
      y.r = 14'(x.r); y.g = 14'(x.g); y.b = 14'(x.b); y.adj = 1'b0;
      return y;
    end
    if (x.a == 0 && x.mv && x.ma != 0) begin
      r = sat_hi(x.mr, ONE); g = sat_hi(x.mg, ONE); b = sat_hi(x.mb, ONE);
      y.a = 13'(ONE);
    end else begin
      r = sat_hi(x.r, ONE); g = sat_hi(x.g, ONE); b = sat_hi(x.b, ONE);
    end
    k = (x.op == OP_STROKE && intens_reg) ? sat_hi(x.inten, ONE) : ONE;
    fh = qmul(sat_hi(hue_reg, ONE), k);
    fs = qmul(sat_hi(sat_reg, 2 * ONE), k);
    fv = qmul(sat_hi(val_reg, 2 * ONE), k);
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    c = mx - mn;
    if (c == 0) begin
      h6 = 0; s = 0;
    end else begin
      if (mx == r) begin num = g - b; base = 0; end
      else if (mx == g) begin num = b - r; base = 2; end
      else begin num = r - g; base = 4; end
      q = (absl(num) * ONE + (c >>> 1)) / c;
      h6 = base * ONE + ((num < 0) ? -q : q);
      if (h6 < 0) h6 += 6 * ONE;
      s = (c * ONE + (mx >>> 1)) / mx;
    end
    v = mx;
    h6 = (h6 + 6 * fh + 3 * ONE) % (6 * ONE);
    s = qmul(s, fs);
    if (s > ONE) s = ONE;
    v = qmul(v, fv);
    y.r = ramp_channel(v, s, clip01(absl(h6 - 3 * ONE) - ONE));
    y.g = ramp_channel(v, s, clip01(2 * ONE - absl(h6 - 2 * ONE)));
    y.b = ramp_channel(v, s, clip01(2 * ONE - absl(h6 - 4 * ONE)));
    y.adj = 1'b1;
    return y;
  endfunction

  // Write one register; only called with the pipeline drained.
  task automatic write_reg(cfg_reg_t idx, longint val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 14'(val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_HUE_OFFSET: hue_reg = val & 14'h1FFF;
      REG_SAT_GAIN: sat_reg = val & 14'h3FFF;
      REG_VAL_GAIN: val_reg = val & 14'h3FFF;
      REG_MODIFY_MODE: mode_reg = 2'(val);
      default: intens_reg = 1'(val);
    endcase
  endtask

  task automatic set_regs(longint h, longint s, longint v, mode_t m, logic ki);
    write_reg(REG_HUE_OFFSET, h);
    write_reg(REG_SAT_GAIN, s);
    write_reg(REG_VAL_GAIN, v);
    write_reg(REG_MODIFY_MODE, m);
    write_reg(REG_USE_INTENSITY, ki);
  endtask

  // Drop valid after the last beat, wait for the pipeline to empty,
  // then let the latency pass.
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Present one beat at a falling edge and hold it until accepted.
  // Valid stays high into the next beat; idling or drain drops it.
  task automatic send_beat(color_beat_t x);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= x.op;
    in_red_in <= x.r; in_green_in <= x.g; in_blue_in <= x.b; in_alpha_in <= x.a;
    in_mat_valid <= x.mv;
    in_mat_red <= x.mr; in_mat_green <= x.mg; in_mat_blue <= x.mb; in_mat_alpha <= x.ma;
    in_intensity <= x.inten;
    do @(posedge clk); while (!in_ready);
    pending_colors.push_back(predict_color(x));
    beats_sent++;
    @(negedge clk);
  endtask

  function automatic logic [12:0] rand_q();
    // Mostly in range, sometimes exactly 0 or 1.0, sometimes anything in 13 bits.
    case ($urandom_range(9, 0))
      0: return 13'($urandom_range(1, 0) ? 0 : 4096);
      1: return 13'($urandom);
      default: return 13'($urandom_range(4096, 0));
    endcase
  endfunction

  function automatic color_beat_t rand_beat();
    color_beat_t x;
    x.op = 1'($urandom);
    x.r = rand_q(); x.g = rand_q(); x.b = rand_q();
    if ($urandom_range(3, 0) == 0) begin x.g = x.r; x.b = x.r; end
    x.a = ($urandom_range(3, 0) == 0) ? 13'd0 : rand_q();
    x.mv = 1'($urandom);
    x.mr = rand_q(); x.mg = rand_q(); x.mb = rand_q();
    x.ma = ($urandom_range(4, 0) == 0) ? 13'd0 : rand_q();
    x.inten = rand_q();
    return x;
  endfunction

  function automatic color_beat_t mk(logic op, int r, int g, int b, int a,
                                     logic mv, int ma, int inten);
    color_beat_t x;
    x.op = op; x.r = 13'(r); x.g = 13'(g); x.b = 13'(b); x.a = 13'(a);
    x.mv = mv; x.mr = 13'd4096; x.mg = 13'd1000; x.mb = 13'd8191;
    x.ma = 13'(ma); x.inten = 13'(inten);
    return x;
  endfunction

  // Extremes, gray, each hue sector, material fallback and its blockers.
  task automatic test_directed();
    color_beat_t list[$];
    list.push_back(mk(OP_FILL, 0, 0, 0, 0, 1'b0, 0, 0));
    list.push_back(mk(OP_FILL, 4096, 4096, 4096, 4096, 1'b0, 0, 0));
    list.push_back(mk(OP_STROKE, 2000, 2000, 2000, 100, 1'b1, 5, 4096));
    list.push_back(mk(OP_FILL, 4096, 0, 0, 4096, 1'b0, 0, 0));
    list.push_back(mk(OP_FILL, 0, 4096, 0, 4096, 1'b0, 0, 0));
    list.push_back(mk(OP_FILL, 0, 0, 4096, 4096, 1'b0, 0, 0));
    list.push_back(mk(OP_FILL, 4096, 100, 3000, 4096, 1'b0, 0, 0));
    list.push_back(mk(OP_STROKE, 300, 4000, 3900, 1, 1'b1, 4096, 8191));
    list.push_back(mk(OP_STROKE, 3000, 10, 4000, 2048, 1'b0, 0, 0));
    list.push_back(mk(OP_FILL, 0, 0, 0, 0, 1'b1, 4096, 0));
    list.push_back(mk(OP_STROKE, 0, 0, 0, 0, 1'b1, 0, 0));
    list.push_back(mk(OP_STROKE, 0, 0, 0, 0, 1'b0, 4096, 0));
    list.push_back(mk(OP_FILL, 8191, 8191, 5000, 8191, 1'b1, 8191, 8191));
    list.push_back(mk(OP_STROKE, 8191, 0, 4097, 0, 1'b1, 8191, 0));
    foreach (list[i]) send_beat(list[i]);
    drain();
  endtask

  // Register sweep: every mode, extremes of every register, intensity on/off.
  task automatic test_modes();
    longint h_vals[5] = '{0, 4096, 8191, 1024, 2048};
    longint g_vals[5] = '{0, 8192, 16383, 2048, 4096};
    color_beat_t x;
    for (int p = 0; p < 5; p++) begin
      set_regs(h_vals[p], g_vals[p], g_vals[4 - p], mode_t'(p % 4), 1'(p));
      for (int i = 0; i < 40; i++) begin
        x = rand_beat();
        send_beat(x);
      end
      drain();
    end
    set_regs(2048, 4096, 4096, MODE_ALL, 1'b1);
    for (int i = 0; i < 20; i++) send_beat(rand_beat());
    drain();
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    set_regs(1500, 6000, 5000, MODE_BOTH, 1'b1);
    recv_hold = 200;
    for (int i = 0; i < 60; i++) send_beat(rand_beat());
    drain();
  endtask

  // Random beats under three idling profiles, random register settings.
  task automatic test_random(int sidle, int ridle, int count);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int blk = 0; blk < 4; blk++) begin
      set_regs($urandom_range(4096, 0), $urandom_range(8192, 0),
               $urandom_range(8192, 0), mode_t'($urandom_range(3, 0)), 1'($urandom));
      for (int i = 0; i < count / 4; i++) send_beat(rand_beat());
      drain();
    end
  endtask

  // Receiver ready: random idling plus an optional long hold-off.
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    adj_color_t exp_c;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        exp_c = pending_colors.pop_front();
        if (out_red_out !== exp_c.r || out_green_out !== exp_c.g ||
            out_blue_out !== exp_c.b || out_alpha_out !== exp_c.a ||
            out_adjusted !== exp_c.adj) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp r%0d g%0d b%0d a%0d adj%0d got r%0d g%0d b%0d a%0d adj%0d",
                     $realtime, exp_c.r, exp_c.g, exp_c.b, exp_c.a, exp_c.adj,
                     out_red_out, out_green_out, out_blue_out, out_alpha_out,
                     out_adjusted);
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("watchdog: no progress, %0d results outstanding", pending_colors.size());
      $display("hsv_color_adjust_tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_modes();
    test_backpressure();
    test_random(6, 62, 500);
    test_random(62, 6, 500);
    test_random(0, 0, 400);
    drain();
    $display("covered %0d beats / %0d results: all modes, register extremes, fallback,",
             beats_sent, results_seen);
    $display("gray and saturated colors, intensity scaling, long output hold-off");
    if (mismatches == 0 && pending_colors.size() == 0) begin
      $display("hsv_color_adjust_tb: clean");
    end else begin
      $display("%0d mismatches, %0d left over", mismatches, pending_colors.size());
      $display("hsv_color_adjust_tb: errors");
    end
    $finish;
  end

endmodule
